>>> hdl/lwtf_pkg.sv
// Package for the lidar window target follower: payload structs, configuration
// record, result mode codes, register indexes and queue sizing.
// No dependencies; every other file of the block uses it by scoped names.
package lwtf_pkg;

	// Scan summaries that may wait between the front and the back part.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int CFG_IDX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN        = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_LIMIT     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_DISTANCE     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_DEADBAND = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HEADING_DEADBAND  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TURN_RATE  = 4'd7;

	// Result modes.
	localparam logic [1:0] MODE_LOST   = 2'd0;
	localparam logic [1:0] MODE_ALIGN  = 2'd1;
	localparam logic [1:0] MODE_FOLLOW = 2'd2;
	localparam logic [1:0] MODE_STOP   = 2'd3;

	typedef struct packed {
		logic        [15:0] point_range;
		logic signed [15:0] point_angle;
		logic               point_ok;
		logic signed [15:0] window_low;
		logic signed [15:0] window_high;
		logic               camera_stale;
		logic               scan_end;
	} point_t;

	typedef struct packed {
		logic        [1:0]  follow_mode;
		logic signed [15:0] linear_cmd;
		logic signed [15:0] angular_cmd;
		logic               target_valid;
		logic        [15:0] target_distance;
		logic signed [15:0] target_bearing;
	} result_t;

	// One finished scan, handed from the front to the back part.
	typedef struct packed {
		logic               tvalid;
		logic        [15:0] near_range;
		logic signed [15:0] bear;
	} scan_t;

	typedef struct packed {
		logic        [11:0] distance_gain;
		logic        [11:0] angle_gain;
		logic        [14:0] linear_limit;
		logic        [14:0] angular_limit;
		logic        [15:0] hold_distance;
		logic        [15:0] distance_deadband;
		logic        [14:0] heading_deadband;
		logic signed [15:0] search_turn_rate;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		distance_gain:     12'd205,
		angle_gain:        12'd384,
		linear_limit:      15'd300,
		angular_limit:     15'd410,
		hold_distance:     16'd700,
		distance_deadband: 16'd250,
		heading_deadband:  15'd1638,
		search_turn_rate:  16'sd287
	};

endpackage

>>> hdl/lwtf_front.sv
// Front part of the lidar window target follower: window test and nearest
// point search over one scan, emits a scan summary on the last point.
// Depends on lwtf_pkg.
module lwtf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  lwtf_pkg::point_t   point,
	output logic               sum_push,
	output lwtf_pkg::scan_t    sum_data
);

	logic        [15:0] nearest_range_q;
	logic signed [15:0] nearest_bearing_q;
	logic               have_q;

	logic signed [15:0] win_min;
	logic signed [15:0] win_max;
	logic               in_window;
	logic               take;
	logic        [15:0] cand_range;
	logic signed [15:0] cand_bearing;
	logic               cand_have;
	logic               tvalid;

	always_comb begin
		if (point.window_low > point.window_high) begin
			win_min = point.window_high;
			win_max = point.window_low;
		end else begin
			win_min = point.window_low;
			win_max = point.window_high;
		end
		in_window = point.point_ok && (point.point_angle >= win_min)
			&& (point.point_angle <= win_max);
		// Strictly smaller range wins, so the earlier point keeps a tie.
		take = in_window && (!have_q || (point.point_range < nearest_range_q));
		cand_range   = take ? point.point_range : nearest_range_q;
		cand_bearing = take ? point.point_angle : nearest_bearing_q;
		cand_have    = have_q || take;
		tvalid       = cand_have && !point.camera_stale;
	end

	assign sum_push            = accept && point.scan_end;
	assign sum_data.tvalid     = tvalid;
	assign sum_data.near_range = tvalid ? cand_range : 16'd0;
	assign sum_data.bear       = tvalid ? cand_bearing : 16'sd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nearest_range_q   <= '0;
			nearest_bearing_q <= '0;
			have_q            <= 1'b0;
		end else if (accept) begin
			if (point.scan_end) begin
				nearest_range_q   <= '0;
				nearest_bearing_q <= '0;
				have_q            <= 1'b0;
			end else begin
				nearest_range_q   <= cand_range;
				nearest_bearing_q <= cand_bearing;
				have_q            <= cand_have;
			end
		end
	end

endmodule

>>> hdl/lwtf_queue.sv
// Short register queue of scan summaries between the front and back parts.
// Depends on lwtf_pkg.
module lwtf_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  lwtf_pkg::scan_t         wr_data,
	input  logic                    rd_en,
	output lwtf_pkg::scan_t         rd_data,
	output logic                    nonempty,
	output logic                    full,
	output logic [lwtf_pkg::QCW-1:0] count
);

	lwtf_pkg::scan_t               slots_q [lwtf_pkg::QDEPTH];
	logic [lwtf_pkg::QAW-1:0]      wr_ptr_q;
	logic [lwtf_pkg::QAW-1:0]      rd_ptr_q;
	logic [lwtf_pkg::QCW-1:0]      count_q;

	assign rd_data  = slots_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign full     = (count_q == lwtf_pkg::QCW'(lwtf_pkg::QDEPTH));
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/lwtf_back.sv
// Back part of the lidar window target follower: mode decision, gain
// products, scaling and saturation, and the result output register.
// Depends on lwtf_pkg.
module lwtf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lwtf_pkg::cfg_t    cfg,
	input  logic              sum_avail,
	input  lwtf_pkg::scan_t   sum_data,
	output logic              sum_pop,
	input  logic              pop,
	output logic              empty,
	output lwtf_pkg::result_t result
);

	// Saturate a scaled product to plus or minus the limit.
	function automatic logic signed [15:0] sat(input logic signed [21:0] v,
		input logic [14:0] lim);
		logic signed [21:0] pl;
		logic signed [21:0] nl;
		logic signed [21:0] r;
		begin
			pl = $signed({7'd0, lim});
			nl = -pl;
			if (v > pl) begin
				r = pl;
			end else if (v < nl) begin
				r = nl;
			end else begin
				r = v;
			end
			sat = r[15:0];
		end
	endfunction

	// Stage 1 decision and products.
	logic signed [16:0] bear17;
	logic        [16:0] abs_a;
	logic signed [16:0] derr;
	logic        [16:0] abs_d;
	logic        [1:0]  mode_c;
	logic signed [29:0] prod_d_c;
	logic signed [28:0] prod_a_c;

	logic               valid_s1;
	logic        [1:0]  mode_s1;
	logic               angle_on_s1;
	logic signed [29:0] prod_d_s1;
	logic signed [28:0] prod_a_s1;
	lwtf_pkg::scan_t    sum_s1;

	logic               valid_s2;
	lwtf_pkg::result_t  res_s2;

	logic               advance2;
	logic               s1_ready;

	logic signed [21:0] sh_d;
	logic signed [21:0] sh_a;
	logic signed [15:0] lin_sat;
	logic signed [15:0] ang_sat;
	logic signed [15:0] ang_neg;
	lwtf_pkg::result_t  res_c;

	always_comb begin
		bear17 = {sum_data.bear[15], sum_data.bear};
		abs_a  = bear17[16] ? 17'(-bear17) : 17'(bear17);
		derr   = $signed({1'b0, sum_data.near_range})
			- $signed({1'b0, cfg.hold_distance});
		abs_d  = derr[16] ? 17'(-derr) : 17'(derr);
		if (!sum_data.tvalid) begin
			mode_c = lwtf_pkg::MODE_LOST;
		end else if (abs_a > {2'b00, cfg.heading_deadband}) begin
			mode_c = lwtf_pkg::MODE_ALIGN;
		end else if (abs_d < {1'b0, cfg.distance_deadband}) begin
			mode_c = lwtf_pkg::MODE_STOP;
		end else begin
			mode_c = lwtf_pkg::MODE_FOLLOW;
		end
		prod_d_c = $signed({1'b0, cfg.distance_gain}) * derr;
		prod_a_c = $signed({1'b0, cfg.angle_gain}) * sum_data.bear;
	end

	assign advance2 = !valid_s2 || pop;
	assign s1_ready = !valid_s1 || advance2;
	assign sum_pop  = sum_avail && s1_ready;

	// Stage 2: floor divide by 256 is an arithmetic shift, then saturate.
	always_comb begin
		sh_d    = prod_d_s1[29:8];
		sh_a    = {prod_a_s1[28], prod_a_s1[28:8]};
		lin_sat = sat(sh_d, cfg.linear_limit);
		ang_sat = sat(sh_a, cfg.angular_limit);
		ang_neg = -ang_sat;

		res_c.follow_mode     = mode_s1;
		res_c.linear_cmd      = '0;
		res_c.angular_cmd     = '0;
		res_c.target_valid    = sum_s1.tvalid;
		res_c.target_distance = sum_s1.near_range;
		res_c.target_bearing  = sum_s1.bear;
		case (mode_s1)
			lwtf_pkg::MODE_LOST: begin
				res_c.angular_cmd = cfg.search_turn_rate;
			end
			lwtf_pkg::MODE_ALIGN: begin
				res_c.angular_cmd = ang_neg;
			end
			lwtf_pkg::MODE_FOLLOW: begin
				res_c.linear_cmd = lin_sat;
				if (angle_on_s1) begin
					res_c.angular_cmd = ang_neg;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sum_pop) begin
			mode_s1     <= mode_c;
			angle_on_s1 <= (abs_a >= {2'b00, cfg.heading_deadband});
			prod_d_s1   <= prod_d_c;
			prod_a_s1   <= prod_a_c;
			sum_s1      <= sum_data;
		end
		if (advance2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= sum_avail;
			end
			if (advance2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign empty  = !valid_s2;
	assign result = res_s2;

endmodule

>>> hdl/lidar_window_target_follower_core.sv
// Top level of the lidar window target follower: configuration registers,
// front point search, summary queue and back command computation.
// Depends on lwtf_pkg, lwtf_front, lwtf_queue and lwtf_back.
//
// Usage: lidar points of a scan are pushed one per transaction on the input
// queue port (push/full). A point may be pushed in every clock cycle. Points
// that are usable and whose bearing lies inside the camera window compete
// for the nearest target; the point flagged scan_end closes the scan and
// produces exactly one result, other points produce none.
// Results are read from the output queue port (empty/pop): while empty is
// low the oldest result is on the result port, and pop takes it.
// Path: a scan_end point's summary is written into the summary queue at the
// accepting edge, then the product stage and the output register take it in
// turn; a result left untaken in the output register holds both back.
// Throughput: one point per cycle. full rises only when the summary queue
// holds its four pending scan results, which can happen only while the
// receiver leaves results untaken; a stalled receiver then stalls the input.
// Configuration writes use cfg_valid/cfg_ready (always ready) with a
// register index and data; unknown indexes are ignored. Writes are expected
// only while no scan result is outstanding.
// Reset (arst_n low) loads the documented register defaults, clears the
// nearest point search and empties the queue and the output register.
module lidar_window_target_follower_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  lwtf_pkg::point_t                  point,
	output logic                              empty,
	input  logic                              pop,
	output lwtf_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lwtf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data
);

	lwtf_pkg::cfg_t              cfg_q;
	logic                        in_accept;
	logic                        sum_push;
	lwtf_pkg::scan_t             sum_wr;
	lwtf_pkg::scan_t             sum_rd;
	logic                        sum_avail;
	logic                        sum_pop;
	logic                        q_full;
	logic [lwtf_pkg::QCW-1:0]    q_count;
	logic                        out_take;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign in_accept = push && !q_full;
	assign out_take  = pop && !empty;

	// Configuration registers; each write keeps the register's own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lwtf_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lwtf_pkg::REG_DISTANCE_GAIN:     cfg_q.distance_gain     <= cfg_data[11:0];
				lwtf_pkg::REG_ANGLE_GAIN:        cfg_q.angle_gain        <= cfg_data[11:0];
				lwtf_pkg::REG_LINEAR_LIMIT:      cfg_q.linear_limit      <= cfg_data[14:0];
				lwtf_pkg::REG_ANGULAR_LIMIT:     cfg_q.angular_limit     <= cfg_data[14:0];
				lwtf_pkg::REG_HOLD_DISTANCE:     cfg_q.hold_distance     <= cfg_data;
				lwtf_pkg::REG_DISTANCE_DEADBAND: cfg_q.distance_deadband <= cfg_data;
				lwtf_pkg::REG_HEADING_DEADBAND:  cfg_q.heading_deadband  <= cfg_data[14:0];
				lwtf_pkg::REG_SEARCH_TURN_RATE:  cfg_q.search_turn_rate  <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// The front closes the scan and hands a summary to the queue.
	lwtf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_accept),
		.point    (point),
		.sum_push (sum_push),
		.sum_data (sum_wr)
	);

	lwtf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (sum_push),
		.wr_data  (sum_wr),
		.rd_en    (sum_pop),
		.rd_data  (sum_rd),
		.nonempty (sum_avail),
		.full     (q_full),
		.count    (q_count)
	);

	// The back turns summaries into commands at its own pace.
	lwtf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.sum_avail (sum_avail),
		.sum_data  (sum_rd),
		.sum_pop   (sum_pop),
		.pop       (out_take),
		.empty     (empty),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	// A lost result never carries a target or a linear command.
	a_lost_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.follow_mode == lwtf_pkg::MODE_LOST) |->
		(result.linear_cmd == 16'sd0 && !result.target_valid
			&& result.target_distance == 16'd0))
		else $error("lost result carries target data or linear command");

	// A valid target always leads to one of the tracking modes.
	a_valid_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.target_valid) |->
		(result.follow_mode != lwtf_pkg::MODE_LOST))
		else $error("valid target reported as lost");

	// Points that do not end a scan never occupy the summary queue.
	a_no_mid_scan_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && !point.scan_end && !sum_pop) |=>
		(q_count == $past(q_count)))
		else $error("summary queue changed on a mid-scan point");

	// The queue count stays within its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_count <= lwtf_pkg::QCW'(lwtf_pkg::QDEPTH)))
		else $error("summary queue count beyond depth");
`endif

endmodule

>>> sim/tb_lidar_window_target_follower_core.sv
// Self-checking testbench for lidar_window_target_follower_core: nearest in-window
// point search, follow mode decision and saturated velocity commands per scan.
// Depends on lwtf_pkg and the RTL of the block; needs no other file.
module tb_lidar_window_target_follower_core;

	// Results leave through the queue, product stage and output register, so a short
	// quiet stretch after the last result is enough before a register write.
	localparam int SETTLE_CYCLES   = 6;
	localparam int TAIL_CYCLES     = 8;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int SQUEEZE_CYCLES  = 200;
	localparam int PHASE_POINTS    = 150;
	localparam int RANDOM_PHASES   = 5;
	localparam logic [lwtf_pkg::CFG_IDX_W-1:0] FIRST_UNUSED_REG =
		lwtf_pkg::REG_SEARCH_TURN_RATE + 1'b1;

	typedef enum logic {FEED_POINT, FEED_WRITE} feed_kind_t;

	// One entry of the stimulus feed: either a lidar point or a register write.
	typedef struct {
		feed_kind_t                     kind;
		lwtf_pkg::point_t               pt;
		logic [lwtf_pkg::CFG_IDX_W-1:0] index;
		logic [15:0]                    data;
	} feed_entry_t;

	// Shadow copy of the register file, widened to int for the arithmetic.
	typedef struct {
		int distance_gain;
		int angle_gain;
		int linear_limit;
		int angular_limit;
		int hold_distance;
		int distance_deadband;
		int heading_deadband;
		int search_turn_rate;
	} follower_tuning_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           push = 1'b0;
	logic                           full;
	lwtf_pkg::point_t               point = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	lwtf_pkg::result_t              result;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [lwtf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                    cfg_data = '0;

	lidar_window_target_follower_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.point     (point),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Stimulus feed and the commands the predictor expects, oldest first.
	feed_entry_t       scan_feed[$];
	lwtf_pkg::result_t pending_commands[$];

	// Predictor state: register shadow and the nearest point of the open scan.
	follower_tuning_t tuning;
	logic [15:0]      near_range;
	logic signed [15:0] near_bearing;
	logic             near_found;

	// Handshake flags raised by the monitor at the rising edge and consumed by
	// the drivers at the following falling edge.
	bit               point_taken;
	bit               write_taken;
	bit               command_taken;

	// Driver and receiver pacing.
	bit               sending_point;
	bit               sending_write;
	bit               all_sent;
	int               send_gap;
	int               send_steady;
	int               settle_count;
	int               recv_gap;
	int               recv_steady;

	// Receiver hold-off that backs the result queue up into the input.
	logic             hold_off = 1'b0;
	bit               squeeze_done;
	int               squeeze_count;
	int               squeeze_after = 32'h7fffffff;

	// Bookkeeping.
	int               writes_planned;
	int               points_accepted;
	int               writes_accepted;
	int               commands_checked;
	int               full_cycles;
	int               mismatches;
	int               quiet_cycles;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Gain times error is exact; the Q8 scaling rounds toward minus infinity,
	// which an arithmetic shift gives directly, then the symmetric clamp.
	function automatic int scaled_clamp(int gain, int err, int limit);
		longint prod;
		prod = longint'(gain) * longint'(err);
		prod = prod >>> 8;
		if (prod > limit)
			prod = limit;
		if (prod < -limit)
			prod = -limit;
		return int'(prod);
	endfunction

	task automatic apply_write(input logic [lwtf_pkg::CFG_IDX_W-1:0] index,
			input logic [15:0] data);
		case (index)
			lwtf_pkg::REG_DISTANCE_GAIN:     tuning.distance_gain     = int'(data[11:0]);
			lwtf_pkg::REG_ANGLE_GAIN:        tuning.angle_gain        = int'(data[11:0]);
			lwtf_pkg::REG_LINEAR_LIMIT:      tuning.linear_limit      = int'(data[14:0]);
			lwtf_pkg::REG_ANGULAR_LIMIT:     tuning.angular_limit     = int'(data[14:0]);
			lwtf_pkg::REG_HOLD_DISTANCE:     tuning.hold_distance     = int'(data);
			lwtf_pkg::REG_DISTANCE_DEADBAND: tuning.distance_deadband = int'(data);
			lwtf_pkg::REG_HEADING_DEADBAND:  tuning.heading_deadband  = int'(data[14:0]);
			lwtf_pkg::REG_SEARCH_TURN_RATE:  tuning.search_turn_rate  = int'($signed(data));
			default: begin
				// Writes to unused indexes change nothing.
			end
		endcase
	endtask

	// Folds one accepted point into the nearest-point search and, on the point
	// that closes the scan, appends the command the block must produce.
	task automatic track_nearest(input lwtf_pkg::point_t p);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] ang;
		lwtf_pkg::result_t cmd;
		int bear;
		int bear_mag;
		int err;
		int err_mag;
		int lin;
		int turn;
		lo = p.window_low;
		hi = p.window_high;
		ang = p.point_angle;
		// A window given upside down is taken with its bounds exchanged.
		if (lo > hi) begin
			lo = p.window_high;
			hi = p.window_low;
		end
		// Strictly nearer replaces, so the first of equal ranges stays.
		if (p.point_ok && ang >= lo && ang <= hi &&
				(!near_found || p.point_range < near_range)) begin
			near_range = p.point_range;
			near_bearing = ang;
			near_found = 1'b1;
		end
		if (p.scan_end) begin
			cmd = '0;
			lin = 0;
			turn = 0;
			if (!near_found || p.camera_stale) begin
				// Nothing seen, or the camera box is too old to trust: search.
				cmd.follow_mode = lwtf_pkg::MODE_LOST;
				turn = tuning.search_turn_rate;
			end else begin
				cmd.target_valid = 1'b1;
				cmd.target_distance = near_range;
				cmd.target_bearing = near_bearing;
				bear = int'(near_bearing);
				bear_mag = (bear < 0) ? -bear : bear;
				err = int'(near_range) - tuning.hold_distance;
				err_mag = (err < 0) ? -err : err;
				if (bear_mag > tuning.heading_deadband) begin
					cmd.follow_mode = lwtf_pkg::MODE_ALIGN;
					turn = -scaled_clamp(tuning.angle_gain, bear, tuning.angular_limit);
				end else if (err_mag < tuning.distance_deadband) begin
					cmd.follow_mode = lwtf_pkg::MODE_STOP;
				end else begin
					cmd.follow_mode = lwtf_pkg::MODE_FOLLOW;
					lin = scaled_clamp(tuning.distance_gain, err, tuning.linear_limit);
					// Only a bearing exactly on the heading deadband turns here.
					if (bear_mag >= tuning.heading_deadband)
						turn = -scaled_clamp(tuning.angle_gain, bear, tuning.angular_limit);
				end
			end
			cmd.linear_cmd = lin[15:0];
			cmd.angular_cmd = turn[15:0];
			pending_commands = {pending_commands, cmd};
			near_range = '0;
			near_bearing = '0;
			near_found = 1'b0;
		end
	endtask

	function automatic string describe(lwtf_pkg::result_t r);
		return $sformatf("mode %0d lin %0d ang %0d valid %0b dist %0d bear %0d",
			r.follow_mode, r.linear_cmd, r.angular_cmd, r.target_valid,
			r.target_distance, r.target_bearing);
	endfunction

	task automatic check_command(input lwtf_pkg::result_t want,
			input lwtf_pkg::result_t got);
		string bad;
		bad = "";
		if (got.follow_mode !== want.follow_mode)
			bad = {bad, " follow_mode"};
		if (got.linear_cmd !== want.linear_cmd)
			bad = {bad, " linear_cmd"};
		if (got.angular_cmd !== want.angular_cmd)
			bad = {bad, " angular_cmd"};
		if (got.target_valid !== want.target_valid)
			bad = {bad, " target_valid"};
		if (got.target_distance !== want.target_distance)
			bad = {bad, " target_distance"};
		if (got.target_bearing !== want.target_bearing)
			bad = {bad, " target_bearing"};
		if (bad != "") begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result %0d differs in%s: expected %s, got %s",
					commands_checked, bad, describe(want), describe(got));
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus construction
	// ------------------------------------------------------------------

	function automatic int clip_s16(int v);
		if (v < -32768)
			return -32768;
		if (v > 32767)
			return 32767;
		return v;
	endfunction

	function automatic int clip_u16(int v);
		if (v < 0)
			return 0;
		if (v > 65535)
			return 65535;
		return v;
	endfunction

	function automatic lwtf_pkg::point_t make_point(int range_mm, int angle, bit ok,
			int lo, int hi, bit stale, bit last);
		lwtf_pkg::point_t p;
		p.point_range = range_mm[15:0];
		p.point_angle = angle[15:0];
		p.point_ok = ok;
		p.window_low = lo[15:0];
		p.window_high = hi[15:0];
		p.camera_stale = stale;
		p.scan_end = last;
		return p;
	endfunction

	task automatic add_point(input lwtf_pkg::point_t p);
		feed_entry_t e;
		e.kind = FEED_POINT;
		e.pt = p;
		e.index = '0;
		e.data = '0;
		scan_feed = {scan_feed, e};
	endtask

	task automatic add_write(input logic [lwtf_pkg::CFG_IDX_W-1:0] index,
			input logic [15:0] data);
		feed_entry_t e;
		e.kind = FEED_WRITE;
		e.pt = '0;
		e.index = index;
		e.data = data;
		scan_feed = {scan_feed, e};
		writes_planned++;
	endtask

	// Mostly zero, now and then a few cycles, rarely a long pause; from time to
	// time a stretch of back-to-back transactions with no gaps at all.
	task automatic draw_gap(inout int steady, output int gap);
		int roll;
		roll = $urandom_range(0, 99);
		if (steady > 0) begin
			steady--;
			gap = 0;
		end else if (roll < 3) begin
			steady = $urandom_range(20, 80);
			gap = 0;
		end else if (roll < 55) begin
			gap = 0;
		end else if (roll < 85) begin
			gap = $urandom_range(1, 3);
		end else if (roll < 97) begin
			gap = $urandom_range(4, 12);
		end else begin
			gap = $urandom_range(20, 60);
		end
	endtask

	function automatic int pick_level(int top, int lo, int hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return 0;
		if (roll < 30)
			return top;
		return $urandom_range(lo, hi);
	endfunction

	// Writes every register with a fresh value; the unused upper data bits
	// carry junk so they are seen to be ignored.
	task automatic plan_tuning(output int hold, output int band, output int head);
		logic [15:0] junk;
		logic [lwtf_pkg::CFG_IDX_W-1:0] spare;
		int v;
		int roll;
		junk = 16'($urandom);
		v = pick_level(4095, 50, 800);
		add_write(lwtf_pkg::REG_DISTANCE_GAIN, {junk[15:12], v[11:0]});
		junk = 16'($urandom);
		v = pick_level(4095, 50, 800);
		add_write(lwtf_pkg::REG_ANGLE_GAIN, {junk[15:12], v[11:0]});
		junk = 16'($urandom);
		v = pick_level(32767, 50, 2000);
		add_write(lwtf_pkg::REG_LINEAR_LIMIT, {junk[15], v[14:0]});
		junk = 16'($urandom);
		v = pick_level(32767, 50, 2000);
		add_write(lwtf_pkg::REG_ANGULAR_LIMIT, {junk[15], v[14:0]});
		hold = pick_level(65535, 200, 4000);
		add_write(lwtf_pkg::REG_HOLD_DISTANCE, hold[15:0]);
		band = pick_level(65535, 0, 600);
		add_write(lwtf_pkg::REG_DISTANCE_DEADBAND, band[15:0]);
		junk = 16'($urandom);
		head = pick_level(32767, 0, 4000);
		add_write(lwtf_pkg::REG_HEADING_DEADBAND, {junk[15], head[14:0]});
		roll = $urandom_range(0, 99);
		if (roll < 15)
			v = -32768;
		else if (roll < 30)
			v = 32767;
		else
			v = int'($urandom_range(0, 2000)) - 1000;
		add_write(lwtf_pkg::REG_SEARCH_TURN_RATE, v[15:0]);
		if ($urandom_range(0, 1)) begin
			spare = lwtf_pkg::CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG,
				(1 << lwtf_pkg::CFG_IDX_W) - 1));
			add_write(spare, 16'($urandom));
		end
	endtask

	// One scan of well-formed points sharing one camera window, or now and then
	// a fully random point. Ranges cluster around the stop band edges and on
	// repeated values, bearings around the window edges and the heading band.
	task automatic add_random_scan(input int hold, input int band, input int head,
			output int added);
		logic [95:0] raw;
		int len;
		int lo;
		int hi;
		int c;
		int w;
		int r;
		int a;
		int roll;
		bit swap;
		bit ok;
		bit last;
		if ($urandom_range(0, 99) < 10) begin
			raw = {$urandom, $urandom, $urandom};
			add_point(raw[$bits(lwtf_pkg::point_t)-1:0]);
			added = 1;
		end else begin
			roll = $urandom_range(0, 99);
			len = (roll < 80) ? $urandom_range(1, 5) : $urandom_range(6, 16);
			roll = $urandom_range(0, 99);
			if (roll < 15) begin
				lo = -32768;
				hi = 32767;
			end else begin
				c = int'($urandom_range(0, 12000)) - 6000;
				w = (roll < 25) ? 0 : $urandom_range(0, 4000);
				lo = clip_s16(c - w);
				hi = clip_s16(c + w);
			end
			swap = ($urandom_range(0, 99) < 15);
			for (int i = 0; i < len; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 60)
					a = lo + int'($urandom_range(0, hi - lo));
				else if (roll < 72)
					a = $urandom_range(0, 1) ? lo : hi;
				else if (roll < 78)
					a = $urandom_range(0, 1) ? clip_s16(lo - 1) : clip_s16(hi + 1);
				else if (roll < 90)
					a = clip_s16(($urandom_range(0, 1) ? 1 : -1) *
						(head + int'($urandom_range(0, 2)) - 1));
				else
					a = int'($urandom_range(0, 65535)) - 32768;
				roll = $urandom_range(0, 99);
				if (roll < 30)
					r = clip_u16(hold + ($urandom_range(0, 1) ? band : -band) +
						int'($urandom_range(0, 4)) - 2);
				else if (roll < 50)
					r = 500 * int'($urandom_range(1, 3));
				else if (roll < 58)
					r = $urandom_range(0, 1) ? 65535 : 0;
				else
					r = $urandom_range(0, 6000);
				ok = ($urandom_range(0, 99) < 88);
				last = (i == len - 1);
				add_point(make_point(r, a, ok, swap ? hi : lo, swap ? lo : hi,
					last && ($urandom_range(0, 99) < 12), last));
			end
			added = len;
		end
	endtask

	// Closes whatever scan is open so that the next register write finds the
	// block with nothing in flight.
	task automatic close_scan();
		add_point(make_point($urandom_range(0, 3000), 0, 1'($urandom_range(0, 1)),
			-32768, 32767, 1'b0, 1'b1));
	endtask

	// ------------------------------------------------------------------
	// Monitor: sees every transaction at the rising edge, runs the predictor
	// and checks results.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_write(cfg_index, cfg_data);
				write_taken = 1'b1;
				writes_accepted++;
			end
			// Results are checked before the new point is folded in, so a
			// command predicted at this edge can never be matched at this edge.
			if (pop && !empty) begin
				command_taken = 1'b1;
				if (pending_commands.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result %0d arrived with nothing expected: %s",
							commands_checked, describe(result));
				end else begin
					check_command(pending_commands.pop_front(), result);
				end
				commands_checked++;
			end
			if (push && full)
				full_cycles++;
			if (push && !full) begin
				track_nearest(point);
				point_taken = 1'b1;
				points_accepted++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Point and register driver, working from the feed at the falling edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (point_taken) begin
				point_taken = 1'b0;
				sending_point = 1'b0;
				draw_gap(send_steady, send_gap);
			end
			if (write_taken) begin
				write_taken = 1'b0;
				sending_write = 1'b0;
			end
			if (!sending_point && !sending_write) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (scan_feed.size() > 0) begin
					if (scan_feed[0].kind == FEED_POINT) begin
						point <= scan_feed[0].pt;
						void'(scan_feed.pop_front());
						sending_point = 1'b1;
					end else begin
						// A register is written only once every result is in and
						// the pipeline has had time to empty.
						settle_count = (pending_commands.size() == 0) ? settle_count + 1 : 0;
						if (settle_count >= SETTLE_CYCLES) begin
							cfg_index <= scan_feed[0].index;
							cfg_data <= scan_feed[0].data;
							void'(scan_feed.pop_front());
							sending_write = 1'b1;
							settle_count = 0;
						end
					end
				end else begin
					all_sent = 1'b1;
				end
			end
			push <= sending_point;
			cfg_valid <= sending_write;
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: random stalls, plus the long hold-off below.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (command_taken) begin
				command_taken = 1'b0;
				draw_gap(recv_steady, recv_gap);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= !hold_off;
			end
		end
	end

	// Once the second random phase has its registers written, the receiver
	// takes nothing for a long stretch while points keep coming, so the summary
	// queue fills and full must push back on the sender.
	always @(negedge clk) begin
		if (arst_n && !squeeze_done && writes_accepted >= squeeze_after) begin
			squeeze_count++;
			if (squeeze_count > SQUEEZE_CYCLES)
				squeeze_done = 1'b1;
			hold_off <= !squeeze_done;
		end
	end

	// Watchdog: a long run of cycles with no transaction at all means the
	// block has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("Timeout: no transaction for %0d cycles, %0d results outstanding",
					quiet_cycles, pending_commands.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int hold;
		int band;
		int head;
		int added;
		int phase_points;

		tuning = '{205, 384, 300, 410, 700, 250, 1638, 287};
		near_range = '0;
		near_bearing = '0;
		near_found = 1'b0;

		// Directed scans at the reset register values.
		// Empty window, with an unusable closing point.
		add_point(make_point(500, 0, 1'b0, -2000, 2000, 1'b0, 1'b1));
		// Far target ahead; a nearer point outside the window is ignored.
		add_point(make_point(1000, 0, 1'b1, -2000, 2000, 1'b0, 1'b0));
		add_point(make_point(900, 5000, 1'b1, -2000, 2000, 1'b0, 1'b0));
		add_point(make_point(0, 0, 1'b0, -2000, 2000, 1'b0, 1'b1));
		// Equal ranges: the first one seen wins, and the range is in the stop band.
		add_point(make_point(700, 100, 1'b1, -2000, 2000, 1'b0, 1'b0));
		add_point(make_point(700, -100, 1'b1, -2000, 2000, 1'b0, 1'b0));
		add_point(make_point(800, 0, 1'b1, -2000, 2000, 1'b0, 1'b1));
		// Window bounds given the wrong way round.
		add_point(make_point(1500, 500, 1'b1, 1000, -1000, 1'b0, 1'b1));
		// Good target but a stale camera frame on the closing point.
		add_point(make_point(1200, 0, 1'b1, -2000, 2000, 1'b0, 1'b0));
		add_point(make_point(1200, 0, 1'b1, -2000, 2000, 1'b1, 1'b1));
		// Off-axis targets on both sides.
		add_point(make_point(900, 4000, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(900, -3000, 1'b1, -32768, 32767, 1'b0, 1'b1));
		// Bearing exactly on the heading deadband: follow with a turn.
		add_point(make_point(2000, 1638, 1'b1, -32768, 32767, 1'b0, 1'b1));
		// Field extremes.
		add_point(make_point(65535, 32767, 1'b1, -32768, 32767, 1'b0, 1'b0));
		add_point(make_point(0, -32768, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(65535, 32767, 1'b1, -32768, 32767, 1'b0, 1'b1));
		// Inclusive window edges, and one step outside each edge.
		add_point(make_point(800, -500, 1'b1, -500, 300, 1'b0, 1'b0));
		add_point(make_point(600, 300, 1'b1, -500, 300, 1'b0, 1'b0));
		add_point(make_point(100, 301, 1'b1, -500, 300, 1'b0, 1'b0));
		add_point(make_point(100, -501, 1'b1, -500, 300, 1'b0, 1'b0));
		add_point(make_point(0, 0, 1'b0, -500, 300, 1'b0, 1'b1));
		// Too close: negative distance error, backing off at the limit.
		add_point(make_point(100, 0, 1'b1, -2000, 2000, 1'b0, 1'b1));
		// Window of a single bearing.
		add_point(make_point(1000, 7, 1'b1, 7, 7, 1'b0, 1'b1));

		// Everything at its top value, deadbands at zero, most negative search
		// turn; junk in the unused data bits and writes to unused indexes.
		add_write(lwtf_pkg::REG_DISTANCE_GAIN, 16'hffff);
		add_write(lwtf_pkg::REG_ANGLE_GAIN, 16'hffff);
		add_write(lwtf_pkg::REG_LINEAR_LIMIT, 16'hffff);
		add_write(lwtf_pkg::REG_ANGULAR_LIMIT, 16'hffff);
		add_write(lwtf_pkg::REG_HOLD_DISTANCE, 16'hffff);
		add_write(lwtf_pkg::REG_DISTANCE_DEADBAND, 16'h0000);
		add_write(lwtf_pkg::REG_HEADING_DEADBAND, 16'h8000);
		add_write(lwtf_pkg::REG_SEARCH_TURN_RATE, 16'h8000);
		add_write(FIRST_UNUSED_REG, 16'hffff);
		add_write({lwtf_pkg::CFG_IDX_W{1'b1}}, 16'h0000);
		add_point(make_point(0, 0, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(65535, 0, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(30000, -1, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(30000, 1, 1'b0, -32768, 32767, 1'b0, 1'b1));
		for (int i = 0; i < 6; i++)
			add_random_scan(65535, 0, 0, added);
		close_scan();

		// Zero limits with large gains, hold at zero, widest heading deadband.
		add_write(lwtf_pkg::REG_DISTANCE_GAIN, 16'h0fff);
		add_write(lwtf_pkg::REG_ANGLE_GAIN, 16'h0fff);
		add_write(lwtf_pkg::REG_LINEAR_LIMIT, 16'h0000);
		add_write(lwtf_pkg::REG_ANGULAR_LIMIT, 16'h8000);
		add_write(lwtf_pkg::REG_HOLD_DISTANCE, 16'h0000);
		add_write(lwtf_pkg::REG_DISTANCE_DEADBAND, 16'h0001);
		add_write(lwtf_pkg::REG_HEADING_DEADBAND, 16'h7fff);
		add_write(lwtf_pkg::REG_SEARCH_TURN_RATE, 16'h7fff);
		add_point(make_point(65535, -32768, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(65535, 32767, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(0, 0, 1'b1, -32768, 32767, 1'b0, 1'b1));
		add_point(make_point(0, 0, 1'b1, -32768, 32767, 1'b1, 1'b1));
		for (int i = 0; i < 6; i++)
			add_random_scan(0, 1, 32767, added);
		close_scan();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			plan_tuning(hold, band, head);
			if (ph == 1)
				squeeze_after = writes_planned;
			phase_points = 0;
			while (phase_points < PHASE_POINTS) begin
				add_random_scan(hold, band, head, added);
				phase_points += added;
			end
			close_scan();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(all_sent && pending_commands.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d points and %0d register writes; %0d scan results checked.",
			points_accepted, writes_accepted, commands_checked);
		$display("Input held back by full for %0d cycles; %0d results wrong or unexpected.",
			full_cycles, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
